// ===== rtl/csc_pkg.sv =====
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types, constants and the arctangent table for the CORDIC sine and
// cosine pipeline.
// ----------------------------------------------------------------------------
package csc_pkg;

    // number of rotation cells in the chain, 8 to 31
    localparam int ITERATIONS = 31;

    // angle and datapath word width
    localparam int WordWidth = 32;

    // shift amount width, enough for shifts up to 31
    localparam int ShiftWidth = 5;

    // quadrant boundaries, full circle is 2^32
    localparam logic [WordWidth-1:0] QuarterTurn   = 32'h3FFF_FFFF;
    localparam logic [WordWidth-1:0] ThreeQuarters = 32'hBFFF_FFFD;

    // starting x, the inverse cordic gain as a negative q31 word
    localparam logic [WordWidth-1:0] StartGain = 32'hB245_8939;

    // rotation vector carried from cell to cell
    typedef struct packed {
        logic [WordWidth-1:0] x;
        logic [WordWidth-1:0] y;
        logic [WordWidth-1:0] z;
    } csc_vec_t;

    // arctangent of 2^-i, full circle is 2^32
    function automatic logic [WordWidth-1:0] csc_atan(input logic [ShiftWidth-1:0] idx);
        logic [WordWidth-1:0] a;
        case (idx)
            5'd0:    a = 32'h1fffffff;
            5'd1:    a = 32'h12e4051d;
            5'd2:    a = 32'h09fb385b;
            5'd3:    a = 32'h051111d4;
            5'd4:    a = 32'h028b0d43;
            5'd5:    a = 32'h0145d7e1;
            5'd6:    a = 32'h00a2f61e;
            5'd7:    a = 32'h00517c55;
            5'd8:    a = 32'h0028be53;
            5'd9:    a = 32'h00145f2e;
            5'd10:   a = 32'h000a2f98;
            5'd11:   a = 32'h000517cc;
            5'd12:   a = 32'h00028be6;
            5'd13:   a = 32'h000145f3;
            5'd14:   a = 32'h0000a2f9;
            5'd15:   a = 32'h0000517c;
            5'd16:   a = 32'h000028be;
            5'd17:   a = 32'h0000145f;
            5'd18:   a = 32'h00000a2f;
            5'd19:   a = 32'h00000517;
            5'd20:   a = 32'h0000028b;
            5'd21:   a = 32'h00000145;
            5'd22:   a = 32'h000000a2;
            5'd23:   a = 32'h00000051;
            5'd24:   a = 32'h00000028;
            5'd25:   a = 32'h00000014;
            5'd26:   a = 32'h0000000a;
            5'd27:   a = 32'h00000005;
            5'd28:   a = 32'h00000002;
            5'd29:   a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/csc_prerot.sv =====
// ----------------------------------------------------------------------------
// csc_prerot
// Quadrant setup stage: folds the phase into the range the rotation chain
// converges over and loads the starting vector.
// ----------------------------------------------------------------------------
module csc_prerot (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [csc_pkg::WordWidth-1:0]     phase,
    output logic                              out_valid,
    input  logic                              out_ready,
    output csc_pkg::csc_vec_t                 out_vec
);

    logic              valid_reg;
    csc_pkg::csc_vec_t vec_reg;
    csc_pkg::csc_vec_t vec_next;

    // stage takes a transaction when empty or when its contents move on
    assign in_ready = !valid_reg || out_ready;

    // quadrant fold
    always_comb begin
        vec_next.y = '0;
        if (phase < csc_pkg::QuarterTurn) begin
            vec_next.x = '0 - csc_pkg::StartGain;
            vec_next.z = phase + csc_pkg::QuarterTurn;
        end else if (phase < csc_pkg::ThreeQuarters) begin
            vec_next.x = csc_pkg::StartGain;
            vec_next.z = phase - csc_pkg::QuarterTurn;
        end else begin
            vec_next.x = '0 - csc_pkg::StartGain;
            vec_next.z = phase - csc_pkg::ThreeQuarters;
        end
    end

    // occupancy flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // payload register
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

// ===== rtl/csc_cell.sv =====
// ----------------------------------------------------------------------------
// csc_cell
// One cordic rotation in rotation mode, registered, with its own occupancy
// flag so bubbles in the chain close up under back-pressure.
// ----------------------------------------------------------------------------
module csc_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [csc_pkg::ShiftWidth-1:0]    shift_amt,
    input  logic [csc_pkg::WordWidth-1:0]     angle,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  csc_pkg::csc_vec_t                 in_vec,
    output logic                              out_valid,
    input  logic                              out_ready,
    output csc_pkg::csc_vec_t                 out_vec
);

    logic              valid_reg;
    csc_pkg::csc_vec_t vec_reg;
    csc_pkg::csc_vec_t vec_next;
    logic [csc_pkg::WordWidth-1:0] xs;
    logic [csc_pkg::WordWidth-1:0] ys;

    assign in_ready = !valid_reg || out_ready;

    // arithmetic shifts of the old x and y
    assign xs = $unsigned($signed(in_vec.x) >>> shift_amt);
    assign ys = $unsigned($signed(in_vec.y) >>> shift_amt);

    // steer by z against a quarter turn, everything wraps
    always_comb begin
        if (in_vec.z >= csc_pkg::QuarterTurn) begin
            vec_next.x = in_vec.x - ys;
            vec_next.y = in_vec.y + xs;
            vec_next.z = in_vec.z - angle;
        end else begin
            vec_next.x = in_vec.x + ys;
            vec_next.y = in_vec.y - xs;
            vec_next.z = in_vec.z + angle;
        end
    end

    // occupancy flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // payload register
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

// ===== rtl/cordic_sin_cos.sv =====
// ----------------------------------------------------------------------------
// cordic_sin_cos
// Pipelined cordic sine and cosine of a 32-bit phase word.
// ----------------------------------------------------------------------------
// A new phase transaction is taken every clock unless a stalled output has
// filled the chain. Each result is registered once in the quadrant setup
// stage and then once in each rotation cell of the chain. Every stage has
// its own valid flag, so a stalled output only holds the stages that are
// full; empty slots further up keep taking transactions until the whole
// chain is occupied. Results are sine and cosine in signed q31; values
// near full scale wrap as two's complement without any flag.
module cordic_sin_cos (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] phase
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [31:0] sine, [63:32] cosine
);

    localparam int Stages = csc_pkg::ITERATIONS;

    logic              vld [0:Stages];
    logic              rdy [0:Stages];
    csc_pkg::csc_vec_t vec [0:Stages];

    // quadrant setup feeds the head of the chain
    csc_prerot u_prerot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .phase     (s_tdata),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_vec   (vec[0])
    );

    // chain of rotation cells, cell i shifts by i
    for (genvar i = 0; i < Stages; i++) begin : g_cell
        csc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_amt (csc_pkg::ShiftWidth'(i)),
            .angle     (csc_pkg::csc_atan(csc_pkg::ShiftWidth'(i))),
            .in_valid  (vld[i]),
            .in_ready  (rdy[i]),
            .in_vec    (vec[i]),
            .out_valid (vld[i+1]),
            .out_ready (rdy[i+1]),
            .out_vec   (vec[i+1])
        );
    end

    // result channel
    assign rdy[Stages] = m_tready;
    assign m_tvalid    = vld[Stages];
    assign m_tdata     = {vec[Stages].x, vec[Stages].y};

    // an empty output slot lets the ready chain through to the input
    a_idle_ready : assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output stage");

    // a taken result frees the whole chain
    a_ready_through : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("ready did not propagate through the chain");

    // nothing comes out straight after reset
    a_reset_empty : assert property (@(posedge aclk)
        aresetn && !$past(aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pipelined cordic sine and cosine block. Phase
// transactions go in with random gaps and results are taken with random
// back-pressure. Each accepted phase is rotated by a bit-exact copy of the
// cordic arithmetic, and each result is compared against the oldest pending
// sine and cosine pair.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import csc_pkg::*;

    localparam int RandomPhases = 1350;
    localparam int DrainCycles  = ITERATIONS + 16;
    localparam int CycleLimit   = 200000;

    // arctangent of 2^-i, full circle is 2^32
    localparam logic [WordWidth-1:0] AtanStep [32] = '{
        32'h1fffffff, 32'h12e4051d, 32'h09fb385b, 32'h051111d4,
        32'h028b0d43, 32'h0145d7e1, 32'h00a2f61e, 32'h00517c55,
        32'h0028be53, 32'h00145f2e, 32'h000a2f98, 32'h000517cc,
        32'h00028be6, 32'h000145f3, 32'h0000a2f9, 32'h0000517c,
        32'h000028be, 32'h0000145f, 32'h00000a2f, 32'h00000517,
        32'h0000028b, 32'h00000145, 32'h000000a2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000a, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

    // holds the sine and cosine pairs still owed by the pipeline
    class sincos_scoreboard;
        logic [WordWidth-1:0] phase_q [$];
        logic [2*WordWidth-1:0] sincos_q [$];
        int errors;

        function new();
            errors = 0;
        endfunction

        // rotation chain: returns {cosine, sine}
        function logic [2*WordWidth-1:0] rotate_phase(logic [WordWidth-1:0] phase);
            logic [WordWidth-1:0] x;
            logic [WordWidth-1:0] y;
            logic [WordWidth-1:0] z;
            logic [WordWidth-1:0] x_shift;
            logic [WordWidth-1:0] y_shift;
            x = StartGain;
            y = '0;
            z = phase;
            // quadrant setup
            if (z < QuarterTurn) begin
                x = -x;
                z = z + QuarterTurn;
            end else if (z < ThreeQuarters) begin
                z = z - QuarterTurn;
            end else begin
                x = -x;
                z = z - ThreeQuarters;
            end
            // rotations, both shifts taken from the old x and y
            for (int i = 0; i < ITERATIONS; i++) begin
                x_shift = $signed(x) >>> i;
                y_shift = $signed(y) >>> i;
                if (z >= QuarterTurn) begin
                    x = x - y_shift;
                    y = y + x_shift;
                    z = z - AtanStep[i];
                end else begin
                    x = x + y_shift;
                    y = y - x_shift;
                    z = z + AtanStep[i];
                end
            end
            return {x, y};
        endfunction

        function void note_phase(logic [WordWidth-1:0] phase);
            phase_q.push_back(phase);
            sincos_q.push_back(rotate_phase(phase));
        endfunction

        function void check_result(logic [2*WordWidth-1:0] got);
            logic [2*WordWidth-1:0] want;
            logic [WordWidth-1:0] phase;
            if (sincos_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transaction, sine %h cosine %h",
                         $time, got[WordWidth-1:0], got[2*WordWidth-1:WordWidth]);
                return;
            end
            want  = sincos_q.pop_front();
            phase = phase_q.pop_front();
            if (got[WordWidth-1:0] !== want[WordWidth-1:0]) begin
                errors++;
                $display("%0t: phase %h sine expected %h actual %h", $time, phase,
                         want[WordWidth-1:0], got[WordWidth-1:0]);
            end
            if (got[2*WordWidth-1:WordWidth] !== want[2*WordWidth-1:WordWidth]) begin
                errors++;
                $display("%0t: phase %h cosine expected %h actual %h", $time, phase,
                         want[2*WordWidth-1:WordWidth], got[2*WordWidth-1:WordWidth]);
            end
        endfunction

        function int pending();
            return sincos_q.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    sincos_scoreboard sincos_sb = new();
    int cycle_count  = 0;
    int send_quiet   = 0;
    int accept_quiet = 0;

    cordic_sin_cos dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // random wait, with occasional stretches of back-to-back traffic
    function automatic int draw_wait(ref int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet_left = $urandom_range(5, 40);
        end
        return $urandom_range(0, 10);
    endfunction

    // one phase transaction; valid stays high across a zero gap
    task automatic send_phase(logic [31:0] phase);
        int gap;
        gap = draw_wait(send_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= phase;
        do @(posedge aclk); while (!s_tready);
        sincos_sb.note_phase(phase);
    endtask

    // cycle limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sincos_sb.check_result(m_tdata);
        end
    end

    // result side back-pressure, one draw per result transaction
    initial begin
        int stall;
        forever begin
            stall = draw_wait(accept_quiet);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // stimulus
    initial begin
        logic [31:0] edge_phases [$];
        logic [31:0] phase;
        // quadrant boundaries, half and full circle, octant points, bit patterns;
        // phases near a quarter turn drive sine to full scale
        edge_phases = '{32'h0000_0000, 32'h0000_0001, QuarterTurn - 1, QuarterTurn,
                        QuarterTurn + 1, 32'h7FFF_FFFF, 32'h8000_0000,
                        ThreeQuarters - 1, ThreeQuarters, ThreeQuarters + 1,
                        32'hC000_0000, 32'hFFFF_FFFF, 32'h2000_0000, 32'h6000_0000,
                        32'hA000_0000, 32'hE000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (edge_phases[k]) begin
            send_phase(edge_phases[k]);
        end
        // random phases, a share of them clustered round the steering boundaries
        repeat (RandomPhases) begin
            case ($urandom_range(0, 9))
                0: phase = QuarterTurn + $urandom_range(0, 32) - 16;
                1: phase = ThreeQuarters + $urandom_range(0, 32) - 16;
                2: phase = ($urandom_range(0, 7) << 29) + $urandom_range(0, 8) - 4;
                default: phase = $urandom();
            endcase
            send_phase(phase);
        end
        s_tvalid <= 1'b0;
        // drain
        while (sincos_sb.pending() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
        if (sincos_sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== cordic_sin_cos.f =====
rtl/csc_pkg.sv
rtl/csc_prerot.sv
rtl/csc_cell.sv
rtl/cordic_sin_cos.sv
test/tb_top.sv
